>>> hw/rtl/mlp2_pkg.sv
// Shared constants for the two-layer ReLU inference block.
// No dependencies.
package mlp2_pkg;

  localparam int HIDDEN_DEF = 5;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int LOSS_W     = 48;

  localparam logic [14:0]       ACT_MAX  = 15'h7fff;
  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } mlp_cmd_t;

endpackage

>>> hw/rtl/mlp2_mul.sv
// Shared signed multiplier with registered product.
// Depends on mlp2_pkg.
module mlp2_mul
  import mlp2_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

>>> hw/rtl/mlp_two_layer_relu_inference_top.v.sv
// Two-layer ReLU network inference with weight store and batch loss.
// Depends on mlp2_pkg and mlp2_mul.
// Load request: taken while idle and written to the weight store, no result.
// Evaluate request: the single shared multiplier visits every weight and then
// squares the error for the loss.
// A new request waits for idle; in_stall stays high until the result is presented.
// Reset clears the sequencer, the output valid and the loss accumulator.
module mlp_two_layer_relu_inference_top
  import mlp2_pkg::*;
#(
  parameter int HIDDEN = HIDDEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic [5:0]               in_weight_index,
  input  logic signed [15:0]       in_weight_value,
  input  logic signed [15:0]       in_feature_zero,
  input  logic signed [15:0]       in_feature_one,
  input  logic signed [15:0]       in_target,
  input  logic                     in_last_in_batch,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_prediction,
  output logic [LOSS_W-1:0]        out_batch_loss,
  output logic                     out_loss_valid
);

  localparam int NUM_W = HIDDEN * 3;
  localparam int AW    = $clog2(NUM_W);
  localparam int UW    = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int ACC_W = 32 + UW;

  localparam logic [1:0] SLOT_X0  = 2'd0;
  localparam logic [1:0] SLOT_X1  = 2'd1;
  localparam logic [1:0] SLOT_OUT = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_SAT  = 7'b0010000,
    S_ERR  = 7'b0100000,
    S_LOSS = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] mem [NUM_W];
  logic [15:0] rdata_r;

  logic signed [15:0]       x0_r, x0_nxt, x1_r, x1_nxt, tgt_r, tgt_nxt;
  logic                     last_r, last_nxt;
  logic [AW-1:0]            waddr_r, waddr_nxt;
  logic [UW-1:0]            unit_r, unit_nxt;
  logic [1:0]               slot_r, slot_nxt;
  logic signed [32:0]       s_r, s_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [31:0]       pred_r, pred_nxt;
  logic [LOSS_W-1:0]        loss_r, loss_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [31:0]       out_pred_r, out_pred_nxt;
  logic [LOSS_W-1:0]        out_loss_r, out_loss_nxt;
  logic                     out_lv_r, out_lv_nxt;

  logic                     in_take, we, re, last_weight, advance;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     mul_en;
  logic signed [PROD_W-1:0] prod;
  logic [14:0]              act;
  logic signed [33:0]       diff;
  logic [33:0]              mag;
  logic                     big;
  logic [LOSS_W-1:0]        sq;
  logic [LOSS_W:0]          lsum;

  assign in_stall    = (state_r != S_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign we          = in_take && (in_command == CMD_LOAD) &&
                       (in_weight_index < 6'(NUM_W));
  assign last_weight = (unit_r == UW'(HIDDEN - 1)) && (slot_r == SLOT_OUT);
  assign re          = (state_r == S_READ) || ((state_r == S_ACC) && !last_weight);
  assign advance     = !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[in_weight_index[AW-1:0]] <= in_weight_value;
    end
    if (re) begin
      rdata_r <= mem[waddr_r];
    end
  end

  // ReLU with rescale to Q8.8 and saturation
  always_comb begin
    act = 15'd0;
    if (!s_r[32] && (|s_r[31:0])) begin
      act = (|s_r[31:23]) ? ACT_MAX : s_r[22:8];
    end
  end

  assign diff = {{2{pred_r[31]}}, pred_r} - {{10{tgt_r[15]}}, tgt_r, 8'd0};
  assign mag  = diff[33] ? (34'd0 - diff) : diff;
  assign big  = |mag[33:32];
  assign sq   = big ? LOSS_MAX : prod[63:16];
  assign lsum = {1'b0, loss_r} + {1'b0, sq};

  always_comb begin
    mul_en = 1'b0;
    mul_a  = {{(MUL_W-16){x0_r[15]}}, x0_r};
    mul_b  = {{(MUL_W-16){rdata_r[15]}}, rdata_r};
    if (state_r == S_MUL) begin
      mul_en = 1'b1;
      case (slot_r)
        SLOT_X0:  mul_a = {{(MUL_W-16){x0_r[15]}}, x0_r};
        SLOT_X1:  mul_a = {{(MUL_W-16){x1_r[15]}}, x1_r};
        default:  mul_a = {{(MUL_W-15){1'b0}}, act};
      endcase
    end else if (state_r == S_ERR) begin
      mul_en = 1'b1;
      mul_a  = {1'b0, mag[31:0]};
      mul_b  = {1'b0, mag[31:0]};
    end
  end

  mlp2_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    state_nxt     = state_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    tgt_nxt       = tgt_r;
    last_nxt      = last_r;
    waddr_nxt     = waddr_r;
    unit_nxt      = unit_r;
    slot_nxt      = slot_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    pred_nxt      = pred_r;
    loss_nxt      = loss_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pred_nxt  = out_pred_r;
    out_loss_nxt  = out_loss_r;
    out_lv_nxt    = out_lv_r;
    if (re) begin
      waddr_nxt = waddr_r + 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (in_take && (in_command == CMD_EVAL)) begin
          x0_nxt    = in_feature_zero;
          x1_nxt    = in_feature_one;
          tgt_nxt   = in_target;
          last_nxt  = in_last_in_batch;
          waddr_nxt = '0;
          unit_nxt  = '0;
          slot_nxt  = SLOT_X0;
          acc_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC: begin
        case (slot_r)
          SLOT_X0: begin
            s_nxt    = prod[32:0];
            slot_nxt = SLOT_X1;
          end
          SLOT_X1: begin
            s_nxt    = s_r + prod[32:0];
            slot_nxt = SLOT_OUT;
          end
          default: begin
            acc_nxt  = acc_r + prod[ACC_W-1:0];
            slot_nxt = SLOT_X0;
            unit_nxt = unit_r + 1'b1;
          end
        endcase
        state_nxt = last_weight ? S_SAT : S_MUL;
      end
      S_SAT: begin
        if ((&acc_r[ACC_W-1:31]) || !(|acc_r[ACC_W-1:31])) begin
          pred_nxt = acc_r[31:0];
        end else begin
          pred_nxt = acc_r[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
        end
        state_nxt = S_ERR;
      end
      S_ERR: state_nxt = S_LOSS;
      S_LOSS: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = pred_r;
          out_lv_nxt    = last_r;
          out_loss_nxt  = '0;
          if (last_r) begin
            out_loss_nxt = lsum[LOSS_W] ? LOSS_MAX : lsum[LOSS_W-1:0];
            loss_nxt     = '0;
          end else begin
            loss_nxt     = lsum[LOSS_W] ? LOSS_MAX : lsum[LOSS_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loss_r      <= loss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    tgt_r      <= tgt_nxt;
    last_r     <= last_nxt;
    waddr_r    <= waddr_nxt;
    unit_r     <= unit_nxt;
    slot_r     <= slot_nxt;
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
    pred_r     <= pred_nxt;
    out_pred_r <= out_pred_nxt;
    out_loss_r <= out_loss_nxt;
    out_lv_r   <= out_lv_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_batch_loss = out_loss_r;
  assign out_loss_valid = out_lv_r;

  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_command == CMD_EVAL)) |=>
      (state_r == S_READ) && (unit_r == '0) && (slot_r == SLOT_X0))
    else $error("evaluate request did not start the sequencer");

  a_mul_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_ACC))
    else $error("multiply not followed by accumulate");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LOSS) && out_valid_r && out_stall) |=>
      (state_r == S_LOSS) && $stable(out_pred_r))
    else $error("pending result overwritten");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LOSS) && advance) |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result not presented");

  a_loss_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LOSS) && advance && last_r) |=> (loss_r == '0))
    else $error("loss accumulator not cleared at end of batch");

endmodule

>>> bench/tb_top.sv
// Testbench for mlp_two_layer_relu_inference_top: weight loads and evaluate requests
// checked against a cycle-free shadow of the network and its batch loss.
// Depends on mlp2_pkg and the RTL of the block.
module tb_top
  import mlp2_pkg::*;
();

  localparam int NUM_W      = 3 * HIDDEN_DEF;
  localparam int NUM_RANDOM = 1670;
  localparam int CALM_TAIL  = 150;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 6 * HIDDEN_DEF + 10;

  typedef struct packed {
    mlp_cmd_t           cmd;
    logic [5:0]         idx;
    logic signed [15:0] wval;
    logic signed [15:0] f0;
    logic signed [15:0] f1;
    logic signed [15:0] tgt;
    logic               last;
  } mlp_request_t;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic [LOSS_W-1:0]  batch_loss;
    logic               loss_valid;
  } mlp_result_t;

  // Shadow copy of the weight store and loss accumulator.
  class mlp_shadow_net;
    localparam longint PRED_HI = 64'sd2147483647;
    localparam longint PRED_LO = -64'sd2147483648;
    localparam longint ACT_LIM = 64'sd32767;

    logic signed [15:0] shadow_weights [NUM_W];
    logic [LOSS_W-1:0]  shadow_loss = '0;
    mlp_result_t        awaited_outputs [$];
    int                 mismatches = 0;

    task report(string msg);
      $display("tb_top: mismatch: %s", msg);
      mismatches++;
    endtask

    function void absorb_request(mlp_request_t r);
      longint      hsum;
      longint      act;
      longint      acc;
      longint      pred;
      longint      diff;
      logic [63:0] mag;
      logic [63:0] sq;
      logic [LOSS_W:0] total;
      mlp_result_t want;
      int          u;
      if (r.cmd == CMD_LOAD) begin
        if (r.idx < NUM_W) shadow_weights[r.idx] = r.wval;
        return;
      end
      acc = 0;
      for (u = 0; u < HIDDEN_DEF; u++) begin
        hsum = longint'(r.f0) * longint'(shadow_weights[3*u])
             + longint'(r.f1) * longint'(shadow_weights[3*u+1]);
        act = 0;
        if (hsum > 0) begin
          act = hsum >>> 8;
          if (act > ACT_LIM) act = ACT_LIM;
        end
        acc += act * longint'(shadow_weights[3*u+2]);
      end
      pred = acc;
      if (pred > PRED_HI) pred = PRED_HI;
      if (pred < PRED_LO) pred = PRED_LO;
      diff = pred - longint'(r.tgt) * 256;
      mag = (diff < 0) ? -diff : diff;
      if (mag >= 64'h1_0000_0000) sq = {16'h0, LOSS_MAX};
      else sq = (mag * mag) >> 16;
      if (sq > {16'h0, LOSS_MAX}) sq = {16'h0, LOSS_MAX};
      total = shadow_loss + sq[LOSS_W-1:0];
      shadow_loss = (total > {1'b0, LOSS_MAX}) ? LOSS_MAX : total[LOSS_W-1:0];
      want.prediction = pred[31:0];
      if (r.last) begin
        want.batch_loss = shadow_loss;
        want.loss_valid = 1'b1;
        shadow_loss     = '0;
      end else begin
        want.batch_loss = '0;
        want.loss_valid = 1'b0;
      end
      awaited_outputs.push_back(want);
    endfunction

    task compare_result(mlp_result_t got);
      mlp_result_t want;
      if (awaited_outputs.size() == 0) begin
        report($sformatf("result with none pending, prediction=%0d", got.prediction));
        return;
      end
      want = awaited_outputs.pop_front();
      if (got.prediction !== want.prediction)
        report($sformatf("prediction got %0d want %0d", got.prediction, want.prediction));
      if (got.batch_loss !== want.batch_loss)
        report($sformatf("batch_loss got %0d want %0d", got.batch_loss, want.batch_loss));
      if (got.loss_valid !== want.loss_valid)
        report($sformatf("loss_valid got %0b want %0b", got.loss_valid, want.loss_valid));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [5:0]         in_weight_index;
  logic signed [15:0] in_weight_value;
  logic signed [15:0] in_feature_zero;
  logic signed [15:0] in_feature_one;
  logic signed [15:0] in_target;
  logic               in_last_in_batch;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_prediction;
  logic [LOSS_W-1:0]  out_batch_loss;
  logic               out_loss_valid;

  mlp_shadow_net net;
  bit            calm;
  bit            hold_req;
  int            nogap;

  mlp_two_layer_relu_inference_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_weight_index  (in_weight_index),
    .in_weight_value  (in_weight_value),
    .in_feature_zero  (in_feature_zero),
    .in_feature_one   (in_feature_one),
    .in_target        (in_target),
    .in_last_in_batch (in_last_in_batch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prediction   (out_prediction),
    .out_batch_loss   (out_batch_loss),
    .out_loss_valid   (out_loss_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd9_600_000);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic signed [15:0] rand_q88();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic mlp_request_t load_req(int idx, logic signed [15:0] val);
    mlp_request_t r;
    r      = mlp_request_t'({$urandom, $urandom, $urandom});
    r.cmd  = CMD_LOAD;
    r.idx  = 6'(idx);
    r.wval = val;
    return r;
  endfunction

  function automatic mlp_request_t eval_req(logic signed [15:0] f0, logic signed [15:0] f1,
                                            logic signed [15:0] tgt, logic last);
    mlp_request_t r;
    r      = mlp_request_t'({$urandom, $urandom, $urandom});
    r.cmd  = CMD_EVAL;
    r.f0   = f0;
    r.f1   = f1;
    r.tgt  = tgt;
    r.last = last;
    return r;
  endfunction

  function automatic mlp_request_t random_req();
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 9) < 7) return load_req($urandom_range(0, NUM_W - 1), rand_q88());
      return load_req($urandom_range(0, 47), rand_q88());
    end
    return eval_req(rand_q88(), rand_q88(), rand_q88(), $urandom_range(0, 7) == 0);
  endfunction

  task automatic drive_payload(mlp_request_t r);
    in_command       <= r.cmd;
    in_weight_index  <= r.idx;
    in_weight_value  <= r.wval;
    in_feature_zero  <= r.f0;
    in_feature_one   <= r.f1;
    in_target        <= r.tgt;
    in_last_in_batch <= r.last;
  endtask

  task automatic send_request(mlp_request_t r);
    in_valid <= 1'b1;
    drive_payload(r);
    do @(posedge clk); while (in_stall !== 1'b0);
    net.absorb_request(r);
  endtask

  task automatic idle_for(int n);
    in_valid <= 1'b0;
    drive_payload(mlp_request_t'({$urandom, $urandom, $urandom}));
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (net.awaited_outputs.size() != 0);
  endtask

  task automatic offer(mlp_request_t r);
    send_request(r);
    if (nogap > 0) nogap--;
    else if (!calm && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 19));
  endtask

  initial begin : result_sink
    mlp_result_t got;
    int          burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got.prediction = out_prediction;
        got.batch_loss = out_batch_loss;
        got.loss_valid = out_loss_valid;
        net.compare_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : request_source
    int k;
    int i;
    net      = new();
    calm     = 1'b0;
    hold_req = 1'b0;
    nogap    = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    drive_payload('0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // units 0-3 positive, unit 4 negative
    for (k = 0; k < NUM_W; k++) offer(load_req(k, (k >= 12) ? 16'sh8000 : 16'sh7fff));
    offer(load_req(47, 16'sh1234));
    offer(eval_req(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0));
    offer(eval_req(16'sh8000, 16'sh8000, 16'sh7fff, 1'b0));
    offer(eval_req(16'sh0000, 16'sh0000, 16'sh0000, 1'b1));
    offer(eval_req(16'sh7fff, 16'sh8000, rand_q88(), 1'b0));
    // negative output weights: prediction floor, then accumulator saturation
    for (k = 0; k < 4; k++) offer(load_req(3 * k + 2, 16'sh8000));
    for (k = 0; k < 5; k++) offer(eval_req(16'sh7fff, 16'sh7fff, 16'sh7fff, k == 4));

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - CALM_TAIL) calm = 1'b1;
      if (i == 400 || i == 1100) begin
        hold_req = 1'b1;
        nogap    = 12;
      end
      if (i % 350 == 175) wait_drained();
      offer(random_req());
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (net.mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> mlp_two_layer_relu_inference_top.f
hw/rtl/mlp2_pkg.sv
hw/rtl/mlp2_mul.sv
hw/rtl/mlp_two_layer_relu_inference_top.v.sv
bench/tb_top.sv
